/* src/rcga_pkg.sv */
// Shared types and constants for the reduced-cost greedy assignment block.
package rcga_pkg;

    localparam int COST_BITS    = 16;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int NUM_IDX      = 32;
    localparam int REM_W        = 7;
    localparam int DEF_TRACKS   = 32;
    localparam int DEF_CLUSTERS = 32;
    localparam int DEF_PASSES   = 3;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 32;

    localparam logic [COST_BITS-1:0] COST_INF = '1;

    // request kinds on s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    // result kinds on m_tuser
    localparam logic [1:0] KIND_MATCH = 2'd0;
    localparam logic [1:0] KIND_TRK   = 2'd1;
    localparam logic [1:0] KIND_CLU   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]     num_clusters;
        logic [CNT_W-1:0]     num_tracks;
        logic [COST_BITS-1:0] cost;
        logic [IDX_W-1:0]     cluster_index;
        logic [IDX_W-1:0]     track_index;
    } req_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR_WR,
        OP_LOAD_WR,
        OP_RUN_INIT,
        OP_RD_ORIG,
        OP_RD_RED,
        OP_RD_CHOICE,
        OP_COPY,
        OP_MIN,
        OP_SUB,
        OP_MIN_RST,
        OP_GR_CMP,
        OP_GR_DEC,
        OP_EMIT_MATCH,
        OP_EMIT_TRK,
        OP_EMIT_CLU
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] c;
        logic [CNT_W-1:0] nt;
        logic [CNT_W-1:0] nc;
    } cmd_t;

    typedef struct packed {
        logic               out_free;
        logic [NUM_IDX-1:0] chv;
        logic [NUM_IDX-1:0] taken;
    } sts_t;

endpackage

/* src/rcga_dp.sv */
// Datapath: cost stores, reduction and greedy registers, result register.
module rcga_dp import rcga_pkg::*; #(
    parameter int MAX_TRACKS = DEF_TRACKS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  req_t                 req,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // out_track, out_cluster, distance, zero pad
    output logic [1:0]           m_tuser,   // kind
    output logic                 m_tlast
);

    localparam int DEPTH  = MAX_TRACKS * NUM_IDX;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [COST_BITS-1:0] orig_mem [DEPTH];
    logic [COST_BITS:0]   red_mem  [DEPTH];   // {below threshold, reduced cost}

    logic [COST_BITS-1:0] thr_reg;
    logic [COST_BITS-1:0] orig_q_reg;
    logic [COST_BITS:0]   red_q_reg;
    logic [COST_BITS-1:0] min_reg;
    logic [IDX_W-1:0]     best_c_reg;
    logic                 best_ok_reg;
    logic                 best_v_reg;
    logic [IDX_W-1:0]     choice_reg [NUM_IDX];
    logic [NUM_IDX-1:0]   chv_reg;
    logic [NUM_IDX-1:0]   taken_reg;
    logic [REM_W-1:0]     rem_reg;
    logic                 mv_reg;
    logic [1:0]           kind_reg;
    logic [IDX_W-1:0]     otrk_reg;
    logic [IDX_W-1:0]     oclu_reg;
    logic [COST_BITS-1:0] dist_reg;
    logic                 olast_reg;

    logic [ADDR_W-1:0]    addr;
    logic [COST_BITS-1:0] red_val;
    logic                 emit;
    logic                 out_free;

    assign red_val  = red_q_reg[COST_BITS-1:0];
    assign out_free = !mv_reg || m_tready;
    assign emit     = (cmd.op == OP_EMIT_MATCH) || (cmd.op == OP_EMIT_TRK) ||
                      (cmd.op == OP_EMIT_CLU);

    // cell address, matched cluster replaces the column on emission reads
    always_comb begin
        if (cmd.op == OP_RD_CHOICE) begin
            addr = ADDR_W'({cmd.t, choice_reg[cmd.t]});
        end else begin
            addr = ADDR_W'({cmd.t, cmd.c});
        end
    end

    // store ports
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CLR_WR:    orig_mem[addr] <= COST_INF;
            OP_LOAD_WR:   orig_mem[addr] <= req.cost;
            OP_RD_ORIG:   orig_q_reg <= orig_mem[addr];
            OP_RD_CHOICE: orig_q_reg <= orig_mem[addr];
            OP_RD_RED:    red_q_reg <= red_mem[addr];
            OP_COPY:      red_mem[addr] <= {orig_q_reg < thr_reg, orig_q_reg};
            OP_SUB: begin
                if (red_val != COST_INF && min_reg != COST_INF) begin
                    red_mem[addr] <= {red_q_reg[COST_BITS], red_val - min_reg};
                end
            end
            default: ;
        endcase
    end

    // minimum and greedy best candidate
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_MIN_RST: begin
                min_reg    <= COST_INF;
                best_v_reg <= 1'b0;
            end
            OP_COPY: begin
                if (orig_q_reg < min_reg) min_reg <= orig_q_reg;
            end
            OP_MIN: begin
                if (red_val < min_reg) min_reg <= red_val;
            end
            OP_GR_CMP: begin
                if (!taken_reg[cmd.c] && red_val < min_reg) begin
                    min_reg     <= red_val;
                    best_c_reg  <= cmd.c;
                    best_ok_reg <= red_q_reg[COST_BITS];
                    best_v_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= COST_INF;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // assignment state and result countdown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chv_reg   <= '0;
            taken_reg <= '0;
            rem_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_RUN_INIT: begin
                    chv_reg   <= '0;
                    taken_reg <= '0;
                    rem_reg   <= REM_W'(cmd.nt) + REM_W'(cmd.nc);
                end
                OP_GR_DEC: begin
                    if (best_v_reg && best_ok_reg) begin
                        choice_reg[cmd.t]     <= best_c_reg;
                        chv_reg[cmd.t]        <= 1'b1;
                        taken_reg[best_c_reg] <= 1'b1;
                        rem_reg               <= rem_reg - 1'b1;
                    end
                end
                default: begin
                    if (emit) rem_reg <= rem_reg - 1'b1;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (emit) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            olast_reg <= (rem_reg == REM_W'(1));
            case (cmd.op)
                OP_EMIT_MATCH: begin
                    kind_reg <= KIND_MATCH;
                    otrk_reg <= cmd.t;
                    oclu_reg <= choice_reg[cmd.t];
                    dist_reg <= orig_q_reg;
                end
                OP_EMIT_TRK: begin
                    kind_reg <= KIND_TRK;
                    otrk_reg <= cmd.t;
                    oclu_reg <= '0;
                    dist_reg <= '0;
                end
                default: begin
                    kind_reg <= KIND_CLU;
                    otrk_reg <= '0;
                    oclu_reg <= cmd.c;
                    dist_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid     = mv_reg;
    assign m_tuser      = kind_reg;
    assign m_tlast      = olast_reg;
    assign m_tdata      = {6'd0, dist_reg, oclu_reg, otrk_reg};
    assign sts.out_free = out_free;
    assign sts.chv      = chv_reg;
    assign sts.taken    = taken_reg;

endmodule

/* src/rcga_ctrl.sv */
// Controller: sequences load, reductions, greedy passes, emission and store clearing.
module rcga_ctrl import rcga_pkg::*; #(
    parameter int MAX_TRACKS   = DEF_TRACKS,
    parameter int MAX_CLUSTERS = DEF_CLUSTERS,
    parameter int PASSES       = DEF_PASSES
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tuser,
    input  req_t req,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam int P_W = $clog2(PASSES + 1);
    localparam logic [IDX_W-1:0] T_LAST_CLR = IDX_W'(MAX_TRACKS - 1);
    localparam logic [IDX_W-1:0] C_LAST_CLR = IDX_W'(NUM_IDX - 1);
    localparam logic [P_W-1:0]   P_LAST     = P_W'(PASSES - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_ROW_INIT, S_ROW_RD, S_ROW_CP, S_ROWS_RD, S_ROWS_WR,
        S_COL_INIT, S_COL_RD, S_COL_MIN, S_COLS_RD, S_COLS_WR,
        S_GR_TRK, S_GR_RD, S_GR_CMP, S_GR_DEC,
        S_EM_M, S_EM_MW, S_EM_T, S_EM_C
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] t_reg, t_next, c_reg, c_next;
    logic [P_W-1:0]   pass_reg, pass_next;
    logic [CNT_W-1:0] nt_reg, nt_next, nc_reg, nc_next;
    logic [CNT_W-1:0] nt_sat, nc_sat;
    logic             last_t, last_c;

    assign nt_sat = (req.num_tracks > CNT_W'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS) : req.num_tracks;
    assign nc_sat = (req.num_clusters > CNT_W'(MAX_CLUSTERS)) ? CNT_W'(MAX_CLUSTERS)
                                                               : req.num_clusters;
    assign last_t   = ({1'b0, t_reg} + 1'b1) == nt_reg;
    assign last_c   = ({1'b0, c_reg} + 1'b1) == nc_reg;
    assign s_tready = (state_reg == S_IDLE);

    // next state and command
    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        c_next     = c_reg;
        pass_next  = pass_reg;
        nt_next    = nt_reg;
        nc_next    = nc_reg;
        cmd        = '{op: OP_NOP, t: t_reg, c: c_reg, nt: nt_reg, nc: nc_reg};
        case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLR_WR;
                c_next = c_reg + 1'b1;
                if (c_reg == C_LAST_CLR) begin
                    c_next = '0;
                    if (t_reg == T_LAST_CLR) begin
                        t_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        t_next = t_reg + 1'b1;
                    end
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_RUN) begin
                        cmd.op    = OP_RUN_INIT;
                        cmd.nt    = nt_sat;
                        cmd.nc    = nc_sat;
                        nt_next   = nt_sat;
                        nc_next   = nc_sat;
                        t_next    = '0;
                        c_next    = '0;
                        pass_next = '0;
                        if (nt_sat != '0 && nc_sat != '0) begin
                            state_next = S_ROW_INIT;
                        end else if (nt_sat != '0) begin
                            state_next = S_EM_T;
                        end else if (nc_sat != '0) begin
                            state_next = S_EM_C;
                        end else begin
                            state_next = S_CLEAR;
                        end
                    end else if ({1'b0, req.track_index} < CNT_W'(MAX_TRACKS) &&
                                 {1'b0, req.cluster_index} < CNT_W'(MAX_CLUSTERS)) begin
                        cmd.op = OP_LOAD_WR;
                        cmd.t  = req.track_index;
                        cmd.c  = req.cluster_index;
                    end
                end
            end
            // row reduction: copy with minimum, then subtract
            S_ROW_INIT: begin
                cmd.op     = OP_MIN_RST;
                state_next = S_ROW_RD;
            end
            S_ROW_RD: begin
                cmd.op     = OP_RD_ORIG;
                state_next = S_ROW_CP;
            end
            S_ROW_CP: begin
                cmd.op = OP_COPY;
                if (last_c) begin
                    c_next     = '0;
                    state_next = S_ROWS_RD;
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_ROW_RD;
                end
            end
            S_ROWS_RD: begin
                cmd.op     = OP_RD_RED;
                state_next = S_ROWS_WR;
            end
            S_ROWS_WR: begin
                cmd.op = OP_SUB;
                if (last_c) begin
                    c_next = '0;
                    if (last_t) begin
                        t_next     = '0;
                        state_next = S_COL_INIT;
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_ROW_INIT;
                    end
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_ROWS_RD;
                end
            end
            // column reduction
            S_COL_INIT: begin
                cmd.op     = OP_MIN_RST;
                state_next = S_COL_RD;
            end
            S_COL_RD: begin
                cmd.op     = OP_RD_RED;
                state_next = S_COL_MIN;
            end
            S_COL_MIN: begin
                cmd.op = OP_MIN;
                if (last_t) begin
                    t_next     = '0;
                    state_next = S_COLS_RD;
                end else begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_COL_RD;
                end
            end
            S_COLS_RD: begin
                cmd.op     = OP_RD_RED;
                state_next = S_COLS_WR;
            end
            S_COLS_WR: begin
                cmd.op = OP_SUB;
                if (last_t) begin
                    t_next = '0;
                    if (last_c) begin
                        c_next     = '0;
                        state_next = S_GR_TRK;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_COL_INIT;
                    end
                end else begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_COLS_RD;
                end
            end
            // greedy passes in track order
            S_GR_TRK, S_GR_DEC: begin
                if (state_reg == S_GR_TRK && !sts.chv[t_reg]) begin
                    cmd.op     = OP_MIN_RST;
                    c_next     = '0;
                    state_next = S_GR_RD;
                end else begin
                    if (state_reg == S_GR_DEC) cmd.op = OP_GR_DEC;
                    if (last_t) begin
                        t_next = '0;
                        if (pass_reg == P_LAST) begin
                            state_next = S_EM_M;
                        end else begin
                            pass_next  = pass_reg + 1'b1;
                            state_next = S_GR_TRK;
                        end
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_GR_TRK;
                    end
                end
            end
            S_GR_RD: begin
                cmd.op     = OP_RD_RED;
                state_next = S_GR_CMP;
            end
            S_GR_CMP: begin
                cmd.op = OP_GR_CMP;
                if (last_c) begin
                    c_next     = '0;
                    state_next = S_GR_DEC;
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_GR_RD;
                end
            end
            // matched pairs: fetch original cost, then emit
            S_EM_M, S_EM_MW: begin
                if (state_reg == S_EM_M && sts.chv[t_reg]) begin
                    cmd.op     = OP_RD_CHOICE;
                    state_next = S_EM_MW;
                end else if (state_reg == S_EM_MW && !sts.out_free) begin
                    cmd.op = OP_NOP;
                end else begin
                    if (state_reg == S_EM_MW) cmd.op = OP_EMIT_MATCH;
                    if (last_t) begin
                        t_next     = '0;
                        state_next = S_EM_T;
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = S_EM_M;
                    end
                end
            end
            S_EM_T: begin
                if (sts.chv[t_reg] || sts.out_free) begin
                    if (!sts.chv[t_reg]) cmd.op = OP_EMIT_TRK;
                    if (last_t) begin
                        t_next     = '0;
                        c_next     = '0;
                        state_next = (nc_reg != '0) ? S_EM_C : S_CLEAR;
                    end else begin
                        t_next = t_reg + 1'b1;
                    end
                end
            end
            S_EM_C: begin
                if (sts.taken[c_reg] || sts.out_free) begin
                    if (!sts.taken[c_reg]) cmd.op = OP_EMIT_CLU;
                    if (last_c) begin
                        c_next     = '0;
                        t_next     = '0;
                        state_next = S_CLEAR;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // state and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            t_reg     <= '0;
            c_reg     <= '0;
            pass_reg  <= '0;
            nt_reg    <= '0;
            nc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            t_reg     <= t_next;
            c_reg     <= c_next;
            pass_reg  <= pass_next;
            nt_reg    <= nt_next;
            nc_reg    <= nc_next;
        end
    end

endmodule

/* src/reduced_cost_greedy_assignment.sv */
// Reduced-cost greedy track-to-cluster assignment, top level.
// Load transfers: one per cycle while idle, no result.
// Run: row and column reductions, then the greedy passes over unassigned tracks, then emission of
//   matches, unmatched tracks and unmatched clusters, held while the result output stalls.
// After each run and after reset the cost store is cleared, all MAX_TRACKS*32 cells, no input taken.
// aresetn is synchronous, active low; threshold resets to 65535.
module reduced_cost_greedy_assignment import rcga_pkg::*; #(
    parameter int MAX_TRACKS   = DEF_TRACKS,
    parameter int MAX_CLUSTERS = DEF_CLUSTERS,
    parameter int PASSES       = DEF_PASSES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // track_index, cluster_index, cost, num_tracks, num_clusters, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_track, out_cluster, distance, zero pad
    output logic [1:0]          m_tuser,   // kind
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    req_t req;
    cmd_t cmd;
    sts_t sts;

    assign req       = req_t'(s_tdata[$bits(req_t)-1:0]);
    assign cfg_ready = 1'b1;

    rcga_ctrl #(
        .MAX_TRACKS  (MAX_TRACKS),
        .MAX_CLUSTERS(MAX_CLUSTERS),
        .PASSES      (PASSES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .req     (req),
        .cmd     (cmd),
        .sts     (sts)
    );

    rcga_dp #(
        .MAX_TRACKS(MAX_TRACKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .req      (req),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/rcga_checker.sv */
// Port-level checker for the assignment block and its bind.
module rcga_checker import rcga_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                m_tlast
);

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // unmatched cluster carries no track and no distance
    a_clu: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_CLU |-> m_tdata[4:0] == '0 && m_tdata[25:10] == '0)
        else $error("unmatched cluster result has track or distance");

    // unmatched track carries no cluster and no distance
    a_trk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TRK |-> m_tdata[25:5] == '0)
        else $error("unmatched track result has cluster or distance");

endmodule

bind reduced_cost_greedy_assignment rcga_checker u_rcga_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
